[rtl/ppck_pkg.sv]
// shared types, register indexes and constants for the pedal power cadence filter
// no dependencies
package ppck_pkg;

   localparam int TIME_W = 32;
   localparam int VOLT_W = 16;
   localparam int WORD_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_DEBOUNCE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_CALIB      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PROC_NOISE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MEAS_NOISE = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_INIT_COV   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_INIT_EST   = 3'd5;

   localparam logic [15:0] RST_DEBOUNCE   = 16'd200;
   localparam logic [23:0] RST_CALIB      = 24'd36239;
   localparam logic [31:0] RST_PROC_NOISE = 32'd655;
   localparam logic [31:0] RST_MEAS_NOISE = 32'd65536;
   localparam logic [31:0] RST_INIT_COV   = 32'd65536;
   localparam logic [15:0] RST_INIT_EST   = 16'd0;

   // ms per minute, numerator of the cadence division
   localparam logic [15:0] MS_PER_MIN = 16'd60000;

   typedef struct packed {
      logic [TIME_W-1:0]        timestamp_ms;
      logic signed [VOLT_W-1:0] strain_mv;
   } req_word_type;

   typedef struct packed {
      logic              accepted;
      logic [WORD_W-1:0] smoothed_power;
      logic [WORD_W-1:0] cadence_rpm;
   } rsp_word_type;

   // Q16.16 estimate to watts, round half up, saturate
   function automatic logic [WORD_W-1:0] round_est(input logic [31:0] x);
      logic [32:0] r;
      r = {1'b0, x} + 33'd32768;
      return r[32] ? 16'hffff : r[31:16];
   endfunction

endpackage

[rtl/ppck_if.sv]
// valid/ready channel interfaces for request and response words
// depends on ppck_pkg
interface ppck_req_if;
   import ppck_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ppck_rsp_if;
   import ppck_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/pedal_power_cadence_kalman.sv]
// pedal event debounce, cadence, raw power and scalar kalman smoother
// depends on ppck_pkg and the channel interfaces in ppck_if
//
//  channel   dir  word                                   accepted when
//  req_ch    in   timestamp_ms, strain_mv                valid && ready
//  rsp_ch    out  accepted, smoothed_power, cadence_rpm  valid && ready
//  csr_*     in   index 0..5, data up to 32 bits         csr_we high
//
// one word at a time: an ignored event only runs the debounce check; an accepted event
// runs a 16-step cadence division (not on the first event), four passes through one
// 32x24 multiplier and a 17-step gain division; either may then wait on rsp
// reset is synchronous and clears all filter state and restores the
// register defaults; a finished word waits in the rsp register while
// the next request may already be taken
module pedal_power_cadence_kalman (
   input  logic                               clock,
   input  logic                               reset,
   ppck_req_if.sink                           req_ch,
   ppck_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [ppck_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [ppck_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ppck_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_CDIV, S_MUL1, S_MUL2, S_PRED,
      S_KDIV, S_MULK, S_XUPD, S_PUPD, S_FINISH
   } state_type;

   // configuration
   logic [15:0] deb_ff;
   logic [23:0] calib_ff;
   logic [31:0] q_ff, r_ff, icov_ff;
   logic [15:0] iest_ff;

   // filter state
   state_type   state_ff, state_in;
   logic        have_last_ff;
   logic [31:0] last_ff;
   logic [15:0] cad_ff;
   logic [31:0] x_ff, cov_ff;

   // per-word working registers
   logic [31:0] t_ff;
   logic [14:0] v_ff;
   logic        acc_ff;
   logic [15:0] raw_ff, k_ff;
   logic [31:0] p_ff;
   logic        zge_ff;
   logic [55:0] prod_ff, prod_in;
   logic [31:0] mul_a;
   logic [23:0] mul_b;

   // shared restoring divider
   logic [32:0] rem_ff, dvs_ff;
   logic [16:0] num_ff, quo_ff;
   logic [4:0]  cnt_ff;
   logic [33:0] trial;
   logic        div_ge;
   logic [33:0] trial_sub;
   logic [16:0] quo_in;

   logic        rsp_valid_ff;
   rsp_word_type rsp_ff;

   logic        req_fire;
   logic [31:0] delta;
   logic [32:0] p_sum;
   logic [31:0] p_sat;
   logic [32:0] den;
   logic [31:0] z;
   logic [33:0] x_up;
   logic [49:0] dn_round;
   logic [31:0] x_dn;
   logic [31:0] d_mag;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

   assign delta = t_ff - last_ff;

   // divider step: shift one numerator bit in, subtract when it fits
   assign trial     = {rem_ff, num_ff[16]};
   assign div_ge    = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign quo_in    = {quo_ff[15:0], div_ge};

   // predict: covariance plus process noise, saturated
   assign p_sum = {1'b0, cov_ff} + {1'b0, q_ff};
   assign p_sat = p_sum[32] ? 32'hffff_ffff : p_sum[31:0];
   assign den   = {1'b0, p_sat} + {1'b0, r_ff};

   assign z     = {raw_ff, 16'd0};
   assign d_mag = zge_ff ? (z - x_ff) : (x_ff - z);

   assign x_up     = {2'b00, x_ff} + {1'b0, prod_ff[48:16]};
   assign dn_round = {1'b0, prod_ff[48:0]} + 50'd65535;
   assign x_dn     = x_ff - dn_round[47:16];

   // operand select for the shared multiplier
   always_comb begin
      mul_a = 32'd0;
      mul_b = 24'd0;
      case (state_ff)
         S_MUL1: begin
            mul_a = {16'd0, cad_ff};
            mul_b = {9'd0, v_ff};
         end
         S_MUL2: begin
            mul_a = prod_ff[31:0];
            mul_b = calib_ff;
         end
         S_MULK: begin
            mul_a = d_mag;
            mul_b = {8'd0, k_ff};
         end
         S_XUPD: begin
            mul_a = p_ff;
            mul_b = {7'd0, 17'h10000 - {1'b0, k_ff}};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 24'd0;
         end
      endcase
   end

   assign prod_in = {24'd0, mul_a} * {32'd0, mul_b};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff   <= RST_DEBOUNCE;
         calib_ff <= RST_CALIB;
         q_ff     <= RST_PROC_NOISE;
         r_ff     <= RST_MEAS_NOISE;
         icov_ff  <= RST_INIT_COV;
         iest_ff  <= RST_INIT_EST;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEBOUNCE:   deb_ff   <= csr_wdata[15:0];
            REG_CALIB:      calib_ff <= csr_wdata[23:0];
            REG_PROC_NOISE: q_ff     <= csr_wdata;
            REG_MEAS_NOISE: r_ff     <= csr_wdata;
            REG_INIT_COV:   icov_ff  <= csr_wdata;
            REG_INIT_EST:   iest_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_CHECK;
         S_CHECK: begin
            if (have_last_ff && (delta < {16'd0, deb_ff})) state_in = S_FINISH;
            else if (have_last_ff && (delta != 32'd0))     state_in = S_CDIV;
            else                                           state_in = S_MUL1;
         end
         S_CDIV:  if (cnt_ff == 5'd0) state_in = S_MUL1;
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_PRED;
         S_PRED:  state_in = (den == 33'd0) ? S_MULK : S_KDIV;
         S_KDIV:  if (cnt_ff == 5'd0) state_in = S_MULK;
         S_MULK:  state_in = S_XUPD;
         S_XUPD:  state_in = S_PUPD;
         S_PUPD:  state_in = S_FINISH;
         S_FINISH: if (!rsp_valid_ff || rsp_ch.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_last_ff <= 1'b0;
         last_ff      <= 32'd0;
         cad_ff       <= 16'd0;
         x_ff         <= 32'd0;
         cov_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prod_ff  <= prod_in;
         // load a finished word, else drop valid once it is taken
         if (state_ff == S_FINISH && (!rsp_valid_ff || rsp_ch.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready)                                        rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: if (req_fire) begin
               t_ff <= req_ch.data.timestamp_ms;
               v_ff <= req_ch.data.strain_mv[15] ? 15'd0 : req_ch.data.strain_mv[14:0];
            end
            S_CHECK: begin
               if (have_last_ff && (delta < {16'd0, deb_ff})) begin
                  acc_ff <= 1'b0;
               end else begin
                  acc_ff       <= 1'b1;
                  have_last_ff <= 1'b1;
                  last_ff      <= t_ff;
                  if (!have_last_ff) begin
                     x_ff   <= {iest_ff, 16'd0};
                     cov_ff <= icov_ff;
                  end
                  // cadence division, 16 quotient bits
                  rem_ff <= 33'd0;
                  dvs_ff <= {1'b0, delta};
                  num_ff <= {MS_PER_MIN, 1'b0};
                  quo_ff <= 17'd0;
                  cnt_ff <= 5'd15;
               end
            end
            S_CDIV, S_KDIV: begin
               rem_ff <= div_ge ? trial_sub[32:0] : trial[32:0];
               num_ff <= {num_ff[15:0], 1'b0};
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  if (state_ff == S_CDIV) cad_ff <= quo_in[15:0];
                  else                    k_ff   <= quo_in[16] ? 16'hffff : quo_in[15:0];
               end
            end
            S_PRED: begin
               raw_ff <= (|prod_ff[55:40]) ? 16'hffff : prod_ff[39:24];
               p_ff   <= p_sat;
               k_ff   <= 16'd0;
               // gain division, 17 quotient bits, upper numerator bits preloaded
               rem_ff <= {2'b00, p_sat[31:1]};
               dvs_ff <= den;
               num_ff <= {p_sat[0], 16'd0};
               quo_ff <= 17'd0;
               cnt_ff <= 5'd16;
            end
            S_MULK: ;
            S_XUPD: begin
               if (zge_ff) x_ff <= (|x_up[33:32]) ? 32'hffff_ffff : x_up[31:0];
               else        x_ff <= x_dn;
            end
            S_PUPD: cov_ff <= prod_ff[47:16];
            S_FINISH: if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_ff.accepted       <= acc_ff;
               rsp_ff.smoothed_power <= round_est(x_ff);
               rsp_ff.cadence_rpm    <= cad_ff;
            end
            default: ;
         endcase
      end
   end

   // innovation sign is taken once the raw power is known
   always_ff @(posedge clock) begin
      if (state_ff == S_PRED) zge_ff <= {(prod_ff[55:40] != 16'd0) ? 16'hffff
                                          : prod_ff[39:24], 16'd0} >= x_ff;
   end

   // a taken request always starts the debounce check
   a_fire_check: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_CHECK) else $error("request not checked");

   // the measurement update never grows the covariance
   a_cov_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PUPD |=> cov_ff <= $past(p_ff)) else $error("covariance grew");

   // once an event is taken the block stays primed until reset
   a_have_last: assert property (@(posedge clock) disable iff (reset)
      !$fell(have_last_ff)) else $error("have_last dropped");

   // an ignored event leaves the filter estimate untouched
   a_ignored: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && have_last_ff && delta < {16'd0, deb_ff})
      |=> $stable(x_ff) && $stable(cad_ff)) else $error("ignored event changed state");

endmodule
